// File: hw/rtl/mcbp_pkg.sv
// ----------------------------------------------------------------------------
// mcbp_pkg
// Command and result codes, and the control bundle shared by the byte pipe.
// ----------------------------------------------------------------------------
package mcbp_pkg;

    typedef enum logic [2:0] {
        CMD_ALLOCATE = 3'd0,
        CMD_FLUSH    = 3'd1,
        CMD_STATUS   = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_NO_CHANNEL = 2'd1,
        RC_OVERFLOW   = 2'd2,
        RC_EMPTY      = 2'd3
    } rc_t;

    typedef struct packed {
        logic ptr_we;
        logic byte_we;
        logic read_ok;
        logic alloc_ok;
        rc_t  rc;
    } ctl_t;

endpackage

// File: hw/rtl/mcbp_exec.sv
// ----------------------------------------------------------------------------
// mcbp_exec
// Per-command update of one channel's pointer entry and the result fields.
// ----------------------------------------------------------------------------
module mcbp_exec
    import mcbp_pkg::*;
#(
    parameter int CHANNELS   = 64,
    parameter int RING_DEPTH = 8192,
    parameter int PTR_W      = 13,
    parameter int CE_W       = 7,
    parameter int NC_W       = 7
) (
    input  logic [2:0]      cmd,
    input  logic [CE_W-1:0] chan_ext,
    input  logic            last_byte,
    input  logic [NC_W-1:0] next_ch,
    input  logic [PTR_W-1:0] wr_old,
    input  logic [PTR_W-1:0] rd_old,
    input  logic            flag_old,
    output logic [PTR_W-1:0] wr_new,
    output logic [PTR_W-1:0] rd_new,
    output logic            flag_new,
    output ctl_t            ctl,
    output logic            not_empty,
    output logic            change_mark
);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    logic             in_range;
    logic [PTR_W-1:0] wr_adv;
    logic [PTR_W-1:0] rd_adv;

    assign in_range = chan_ext < CE_W'(CHANNELS);
    assign wr_adv   = ring_next(wr_old);
    assign rd_adv   = ring_next(rd_old);

    always_comb begin
        wr_new       = wr_old;
        rd_new       = rd_old;
        flag_new     = flag_old;
        ctl          = '0;
        ctl.rc       = RC_OK;
        not_empty    = 1'b0;
        change_mark  = 1'b0;
        if (cmd_t'(cmd) == CMD_ALLOCATE) begin
            if (next_ch <= NC_W'(CHANNELS - 1)) begin
                ctl.alloc_ok = 1'b1;
            end else begin
                ctl.rc = RC_NO_CHANNEL;
            end
        end else if (in_range) begin
            case (cmd_t'(cmd))
                CMD_FLUSH: begin
                    wr_new     = '0;
                    rd_new     = '0;
                    flag_new   = 1'b0;
                    ctl.ptr_we = 1'b1;
                end
                CMD_WRITE: begin
                    if (wr_adv == rd_old) begin
                        ctl.rc = RC_OVERFLOW;
                    end else begin
                        wr_new      = wr_adv;
                        flag_new    = flag_old | last_byte;
                        ctl.ptr_we  = 1'b1;
                        ctl.byte_we = 1'b1;
                    end
                end
                CMD_READ: begin
                    ctl.ptr_we = 1'b1;
                    if (rd_old == wr_old) begin
                        flag_new = 1'b0;
                        ctl.rc   = RC_EMPTY;
                    end else begin
                        rd_new      = rd_adv;
                        ctl.read_ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            not_empty   = wr_new != rd_new;
            change_mark = flag_new;
        end
    end

endmodule

// File: hw/rtl/multi_channel_byte_pipe_core.sv
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe_core
// Byte ring buffers for many channels in one shared byte memory, with the
// per-channel pointers and change marks in a second memory.
//
//   channel | ports                                         | dir
//   s_      | command, channel, data_in, last_byte          | in
//   m_      | data_out, channel_out, result_code, not_empty,| out
//           | change_mark                                   |
//
// Each command passes transfer with pointer memory read, then update and byte
// memory access in ST_EXEC, then result hand-off in ST_DONE, which raises m_valid.
// One command in flight; the next is taken while a result waits on m_.
// After reset a clearing pass zeroes the pointer memory;
// s_ready stays low meanwhile.
// A stalled result holds the pipe only once the next result is ready too.
// ----------------------------------------------------------------------------
module multi_channel_byte_pipe_core
    import mcbp_pkg::*;
#(
    parameter int CHANNELS      = 64,
    parameter int RING_DEPTH    = 8192,
    parameter int FIRST_CHANNEL = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [5:0] s_channel,
    input  logic [7:0] s_data_in,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_out,
    output logic [5:0] m_channel_out,
    output logic [1:0] m_result_code,
    output logic       m_not_empty,
    output logic       m_change_mark
);

    localparam int CH_W    = (CHANNELS > 2) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CE_W    = ((CH_W > 6) ? CH_W : 6) + 1;
    localparam int NC_W    = ($clog2(CHANNELS + 1) > 6) ? $clog2(CHANNELS + 1) : 6;
    localparam int ENT_W   = 2 * PTR_W + 1;
    localparam int BYTES   = CHANNELS << PTR_W;
    localparam int BADDR_W = CH_W + PTR_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CH_W-1:0]   clr_cnt_reg;
    logic [NC_W-1:0]   next_ch_reg;
    logic [2:0]        cmd_reg;
    logic [CE_W-1:0]   chan_reg;
    logic [7:0]        din_reg;
    logic              last_reg;
    logic [ENT_W-1:0]  ptr_q_reg;
    logic [7:0]        byte_q_reg;
    logic [5:0]        chout_reg;
    rc_t               rc_reg;
    logic              ne_reg;
    logic              cm_reg;
    logic              read_ok_reg;

    logic [ENT_W-1:0]  ptr_mem [CHANNELS];
    logic [7:0]        byte_mem [BYTES];

    logic              s_xfer;
    logic [CE_W-1:0]   s_chan_ext;
    logic [PTR_W-1:0]  wr_new;
    logic [PTR_W-1:0]  rd_new;
    logic              flag_new;
    ctl_t              ctl;
    logic              ne;
    logic              cm;
    logic              ptr_we;
    logic [CH_W-1:0]   ptr_waddr;
    logic [ENT_W-1:0]  ptr_wdata;
    logic [BADDR_W-1:0] byte_addr;

    assign s_ready    = state_reg == ST_IDLE;
    assign s_xfer     = s_valid && s_ready;
    assign s_chan_ext = CE_W'(s_channel);

    mcbp_exec #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH),
        .PTR_W      (PTR_W),
        .CE_W       (CE_W),
        .NC_W       (NC_W)
    ) u_exec (
        .cmd         (cmd_reg),
        .chan_ext    (chan_reg),
        .last_byte   (last_reg),
        .next_ch     (next_ch_reg),
        .wr_old      (ptr_q_reg[PTR_W-1:0]),
        .rd_old      (ptr_q_reg[2*PTR_W-1:PTR_W]),
        .flag_old    (ptr_q_reg[2*PTR_W]),
        .wr_new      (wr_new),
        .rd_new      (rd_new),
        .flag_new    (flag_new),
        .ctl         (ctl),
        .not_empty   (ne),
        .change_mark (cm)
    );

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ptr_we    = 1'b1;
            ptr_waddr = clr_cnt_reg;
            ptr_wdata = '0;
        end else begin
            ptr_we    = (state_reg == ST_EXEC) && ctl.ptr_we;
            ptr_waddr = chan_reg[CH_W-1:0];
            ptr_wdata = {flag_new, rd_new, wr_new};
        end
    end

    assign byte_addr = {chan_reg[CH_W-1:0],
                        ctl.byte_we ? ptr_q_reg[PTR_W-1:0] : ptr_q_reg[2*PTR_W-1:PTR_W]};

    always_ff @(posedge aclk) begin
        if (ptr_we) begin
            ptr_mem[ptr_waddr] <= ptr_wdata;
        end
        if (s_xfer) begin
            ptr_q_reg <= ptr_mem[s_chan_ext[CH_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            if (ctl.byte_we) begin
                byte_mem[byte_addr] <= din_reg;
            end
            byte_q_reg <= byte_mem[byte_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            next_ch_reg <= NC_W'(FIRST_CHANNEL);
            m_valid     <= 1'b0;
        end else begin
            // ST_DONE reloads m_valid itself
            if (m_valid && m_ready && (state_reg != ST_DONE)) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_cnt_reg == CH_W'(CHANNELS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (s_xfer) begin
                        cmd_reg   <= s_command;
                        chan_reg  <= s_chan_ext;
                        din_reg   <= s_data_in;
                        last_reg  <= s_last_byte;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    rc_reg      <= ctl.rc;
                    ne_reg      <= ne;
                    cm_reg      <= cm;
                    read_ok_reg <= ctl.read_ok;
                    chout_reg   <= ctl.alloc_ok ? next_ch_reg[5:0] : 6'd0;
                    if (ctl.alloc_ok) begin
                        next_ch_reg <= next_ch_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid       <= 1'b1;
                        m_data_out    <= read_ok_reg ? byte_q_reg : 8'd0;
                        m_channel_out <= chout_reg;
                        m_result_code <= rc_reg;
                        m_not_empty   <= ne_reg;
                        m_change_mark <= cm_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/mcbp_checker.sv
// ----------------------------------------------------------------------------
// mcbp_checker
// Port-level checks on the byte pipe results, bound to the top level.
// ----------------------------------------------------------------------------
module mcbp_checker
    import mcbp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_out,
    input logic [5:0] m_channel_out,
    input logic [1:0] m_result_code,
    input logic       m_not_empty,
    input logic       m_change_mark
);

    // stalled result transfer holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out)
            && $stable(m_result_code))
        else $error("result changed while stalled");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data_out != 8'd0) |-> m_result_code == RC_OK
            && m_channel_out == 6'd0)
        else $error("byte returned on a failed or non-read command");

    a_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_channel_out != 6'd0) |-> m_result_code == RC_OK
            && !m_not_empty && !m_change_mark)
        else $error("allocate result carries channel status");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code == RC_EMPTY) |-> !m_not_empty && !m_change_mark)
        else $error("empty read left data or change mark");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_code == RC_OVERFLOW) |-> m_not_empty)
        else $error("overflow on a ring that holds no data");

endmodule

bind multi_channel_byte_pipe_core mcbp_checker u_mcbp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_out    (m_data_out),
    .m_channel_out (m_channel_out),
    .m_result_code (m_result_code),
    .m_not_empty   (m_not_empty),
    .m_change_mark (m_change_mark)
);
